### hw/rtl/packet_coincidence_grouper_defines.svh
// Assertion macros used by the checker file of the packet coincidence grouper.
`ifndef PACKET_COINCIDENCE_GROUPER_DEFINES_SVH
`define PACKET_COINCIDENCE_GROUPER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pcg_pkg.sv
// Types and constants of the packet coincidence grouper.
`timescale 1ns / 1ps

package pcg_pkg;

  localparam int NS_W = 30;
  localparam int SLOT_MASK_W = 4;
  localparam int SLOTS_PER_MODULE = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULE_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_THRESHOLD = 1'b1;

  localparam logic [7:0] MODE_PULSE_HEIGHT = 8'h01;
  localparam logic [7:0] MODE_IMG16_A = 8'h02;
  localparam logic [7:0] MODE_IMG16_B = 8'h03;
  localparam logic [7:0] MODE_IMG8_A = 8'h06;
  localparam logic [7:0] MODE_IMG8_B = 8'h07;

  localparam logic [NS_W-1:0] SPAN_THRESHOLD_RESET = 30'd100;

  typedef enum logic [2:0] {
    ACT_UNKNOWN_MODULE = 3'd0,
    ACT_UNKNOWN_MODE   = 3'd1,
    ACT_COINCIDENCE    = 3'd2,
    ACT_STORED         = 3'd3,
    ACT_FLUSHED        = 3'd4
  } action_e;

  typedef struct packed {
    logic [5:0]      module_req;
    logic [1:0]      sensor_slot;
    logic [7:0]      pkt_mode;
    logic [NS_W-1:0] stamp_ns;
  } in_word_t;

  typedef struct packed {
    action_e         action;
    logic            packet_wide;
    logic [3:0]      flushed_slots;
    logic            flushed_wide;
    logic [NS_W-1:0] flushed_low_ns;
    logic [NS_W-1:0] flushed_high_ns;
  } out_word_t;

  // One group record per module, as kept in the group memory.
  typedef struct packed {
    logic [SLOT_MASK_W-1:0] slots;
    logic                   wide;
    logic [NS_W-1:0]        low;
    logic [NS_W-1:0]        high;
  } group_t;

  localparam int GROUP_W = $bits(group_t);

endpackage

### hw/rtl/pcg_stream_if.sv
// Valid/ready stream interface carrying one word of type T.
`timescale 1ns / 1ps

interface pcg_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/pcg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/packet_coincidence_grouper.sv
// Top level of the packet coincidence grouper.
`timescale 1ns / 1ps
// Groups image packet headers per module into frames.
// in_i takes one header word (module, slot, mode, stamp) per valid/ready
// handshake; out_o gives exactly one result word per header, in order.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle: index 0 is the module enable mask, index 1 the span
// threshold in ns.
// An accepted header is held in the compute stage register, and its result
// is registered in the output register, from which out_o presents it.
// Throughput: one header per cycle while out_o does not stall. The per-module
// group records sit in one memory with a registered read, issued at accept;
// the record is updated and written back as its header leaves the compute
// stage; a write-back register forwards it for back-to-back same-module hits.
// Reset clears all group records at once through a per-module valid bit, the
// enable mask to zero and the threshold to 100; no clearing pass is needed.
// When out_o stalls, the result holds in the output register, one more header
// is still taken into the compute stage, and then in_i.ready drops until the
// output drains.
module packet_coincidence_grouper
  import pcg_pkg::*;
#(
  parameter int MODULES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pcg_stream_if.sink            in_i,
  pcg_stream_if.source          out_o
);

  localparam int AW = (MODULES > 1) ? $clog2(MODULES) : 1;

  // configuration
  logic [MODULES-1:0] enable_q;
  logic [NS_W-1:0]    span_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= '0;
      span_thr_q <= SPAN_THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODULE_ENABLE:  enable_q   <= cfg_data_i[MODULES-1:0];
        CFG_SPAN_THRESHOLD: span_thr_q <= cfg_data_i[NS_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  logic     accept;
  logic     out_adv;
  logic     s1_fire;
  logic     s1_valid_q;
  in_word_t s1_word_q;
  logic     s1_entry_vld_q;
  logic     out_valid_q;
  out_word_t out_word_q;

  assign out_adv  = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_adv;
  assign accept   = in_i.valid && in_i.ready;
  assign s1_fire  = s1_valid_q && out_adv;

  // memory and per-entry valid bits
  logic [AW-1:0]      rd_addr;
  logic               rd_in_range;
  logic [MODULES-1:0] entry_vld_q;
  logic               ram_we;
  logic [AW-1:0]      s1_addr;
  group_t             ram_rdata;
  group_t             grp_new;
  logic [GROUP_W-1:0] ram_rdata_raw;

  assign rd_addr     = in_i.data.module_req[AW-1:0];
  assign rd_in_range = 32'(in_i.data.module_req) < MODULES;
  assign s1_addr     = s1_word_q.module_req[AW-1:0];

  pcg_ram #(
    .WIDTH (GROUP_W),
    .DEPTH (MODULES)
  ) u_group_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (grp_new),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = group_t'(ram_rdata_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q      <= in_i.data;
      s1_entry_vld_q <= rd_in_range ? entry_vld_q[rd_addr] : 1'b0;
    end
  end

  // write-back forwarding: last record written, valid until an item leaves
  // the compute stage without writing a record
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  group_t        fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      entry_vld_q <= '0;
    end else if (s1_fire) begin
      fwd_valid_q <= ram_we;
      if (ram_we) begin
        entry_vld_q[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= grp_new;
    end
  end

  // compute stage
  group_t          grp_cur;
  logic            mod_ok;
  logic            is_wide;
  logic            is_image;
  logic            slot_ok;
  logic [3:0]      slot_bit;
  logic [NS_W-1:0] lo;
  logic [NS_W-1:0] hi;
  logic [NS_W-1:0] span;
  logic            flush;
  out_word_t       res;

  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      grp_cur = fwd_data_q;
    end else if (s1_entry_vld_q) begin
      grp_cur = ram_rdata;
    end else begin
      grp_cur = '0;
    end
  end

  always_comb begin
    mod_ok   = (32'(s1_word_q.module_req) < MODULES) ? enable_q[s1_addr] : 1'b0;
    is_wide  = (s1_word_q.pkt_mode == MODE_IMG16_A) || (s1_word_q.pkt_mode == MODE_IMG16_B);
    is_image = is_wide ||
               (s1_word_q.pkt_mode == MODE_IMG8_A) || (s1_word_q.pkt_mode == MODE_IMG8_B);
    slot_ok  = 32'(s1_word_q.sensor_slot) < SLOTS_PER_MODULE;
    slot_bit = 4'(1) << s1_word_q.sensor_slot;
    lo       = (s1_word_q.stamp_ns < grp_cur.low) ? s1_word_q.stamp_ns : grp_cur.low;
    hi       = (s1_word_q.stamp_ns > grp_cur.high) ? s1_word_q.stamp_ns : grp_cur.high;
    span     = hi - lo;
    flush    = (grp_cur.slots != '0) &&
               (((grp_cur.slots & slot_bit) != '0) || (grp_cur.wide != is_wide) ||
                (span > span_thr_q));

    res     = '0;
    grp_new = grp_cur;
    ram_we  = 1'b0;
    if (!mod_ok) begin
      res.action = ACT_UNKNOWN_MODULE;
    end else if (s1_word_q.pkt_mode == MODE_PULSE_HEIGHT) begin
      res.action = ACT_COINCIDENCE;
    end else if (!is_image || !slot_ok) begin
      res.action = ACT_UNKNOWN_MODE;
    end else begin
      res.packet_wide = is_wide;
      ram_we          = s1_fire;
      if (grp_cur.slots == '0 || flush) begin
        // open or restart the group with this packet alone
        grp_new.slots = slot_bit;
        grp_new.wide  = is_wide;
        grp_new.low   = s1_word_q.stamp_ns;
        grp_new.high  = s1_word_q.stamp_ns;
      end else begin
        grp_new.slots = grp_cur.slots | slot_bit;
        grp_new.low   = lo;
        grp_new.high  = hi;
      end
      if (flush) begin
        res.action          = ACT_FLUSHED;
        res.flushed_slots   = grp_cur.slots;
        res.flushed_wide    = grp_cur.wide;
        res.flushed_low_ns  = grp_cur.low;
        res.flushed_high_ns = grp_cur.high;
      end else begin
        res.action = ACT_STORED;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_word_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule

### hw/rtl/pcg_checker.sv
// Port-level checker of the packet coincidence grouper, with its bind.
`timescale 1ns / 1ps
`include "packet_coincidence_grouper_defines.svh"

module pcg_checker
  import pcg_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_data_i
);

  // a stalled result word holds
  `PCG_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, $stable(out_data_i),
    "result word changed while stalled")

  // input backs up only behind a stalled output
  `PCG_ASSERT_IMP(a_ready_low, !in_ready_i, out_valid_i && !out_ready_i,
    "input not ready while output is free")

  // dropped or routed packets carry no width and no flushed group
  `PCG_ASSERT_IMP(a_drop_clean,
    out_valid_i && (out_data_i.action == ACT_UNKNOWN_MODULE ||
                    out_data_i.action == ACT_UNKNOWN_MODE ||
                    out_data_i.action == ACT_COINCIDENCE),
    !out_data_i.packet_wide && out_data_i.flushed_slots == '0 &&
    out_data_i.flushed_low_ns == '0 && out_data_i.flushed_high_ns == '0,
    "dropped packet carries group fields")

  // a flushed group is never empty and its span is ordered
  `PCG_ASSERT_IMP(a_flush_group,
    out_valid_i && out_data_i.action == ACT_FLUSHED,
    out_data_i.flushed_slots != '0 &&
    out_data_i.flushed_low_ns <= out_data_i.flushed_high_ns,
    "flushed group empty or inverted")

endmodule

bind packet_coincidence_grouper pcg_checker u_pcg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
